// ===== rtl/core/tft_pkg.sv =====
// ----------------------------------------------------------------------------
// tft_pkg
// Shared types, constants and arithmetic helpers of the tool tip feedrate core.
// ----------------------------------------------------------------------------
`default_nettype none

package tft_pkg;

   localparam int DataWidth = 32;
   localparam int RateWidth = 17;

   localparam logic [16:0] RateReset = 17'd1000;
   localparam logic [32:0] Deg2Rad   = 33'd74961321;
   localparam logic [32:0] Turn      = 33'd23592960;
   localparam logic [32:0] Quarter   = 33'd5898240;
   localparam logic [31:0] One30     = 32'h4000_0000;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] a;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dz;
      logic signed [32:0] da;
      logic signed [32:0] db;
   } item_type;

   typedef struct packed {
      logic [32:0] a;
      logic [32:0] b;
      logic [5:0]  sh;
      logic        rnd;
   } mul_req_type;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      return v[32] ? 33'(-v) : 33'(v);
   endfunction

   function automatic logic signed [31:0] sat_mag(input logic [65:0] m, input logic neg);
      logic [65:0] lim;
      logic [31:0] v;
      lim = 66'(32'h7fff_ffff) + 66'(neg);
      v = (m > lim) ? lim[31:0] : m[31:0];
      return neg ? $signed(32'(-v)) : $signed(v);
   endfunction

   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) begin
         r = 32'sh7fff_ffff;
      end else if (v < -34'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [8:0] den_sin(input logic [3:0] k);
      logic [8:0] d;
      case (k)
         4'd1: d = 9'd6;
         4'd2: d = 9'd20;
         4'd3: d = 9'd42;
         4'd4: d = 9'd72;
         4'd5: d = 9'd110;
         4'd6: d = 9'd156;
         4'd7: d = 9'd210;
         4'd8: d = 9'd272;
         default: d = 9'd342;
      endcase
      return d;
   endfunction

   function automatic logic [8:0] den_cos(input logic [3:0] k);
      logic [8:0] d;
      case (k)
         4'd1: d = 9'd2;
         4'd2: d = 9'd12;
         4'd3: d = 9'd30;
         4'd4: d = 9'd56;
         4'd5: d = 9'd90;
         4'd6: d = 9'd132;
         4'd7: d = 9'd182;
         4'd8: d = 9'd240;
         default: d = 9'd306;
      endcase
      return d;
   endfunction

   // Reciprocals are floor(2^32 / d) for the denominators above.
   function automatic logic [31:0] recip_sin(input logic [3:0] k);
      logic [31:0] r;
      case (k)
         4'd1: r = 32'd715827882;
         4'd2: r = 32'd214748364;
         4'd3: r = 32'd102261126;
         4'd4: r = 32'd59652323;
         4'd5: r = 32'd39045157;
         4'd6: r = 32'd27531841;
         4'd7: r = 32'd20452225;
         4'd8: r = 32'd15790320;
         default: r = 32'd12558383;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] recip_cos(input logic [3:0] k);
      logic [31:0] r;
      case (k)
         4'd1: r = 32'd2147483648;
         4'd2: r = 32'd357913941;
         4'd3: r = 32'd143165576;
         4'd4: r = 32'd76695844;
         4'd5: r = 32'd47721858;
         4'd6: r = 32'd32537631;
         4'd7: r = 32'd23598721;
         4'd8: r = 32'd17895697;
         default: r = 32'd14035840;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tft_channels.sv =====
// ----------------------------------------------------------------------------
// tft_channels
// Valid/ready channel interfaces for samples, results and the rate register.
// ----------------------------------------------------------------------------
`default_nettype none

interface tft_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] tool_offset;
   logic signed [31:0] angle_a;
   logic signed [31:0] angle_b;
   modport source (output valid, pos_x, pos_y, pos_z, tool_offset, angle_a, angle_b,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, tool_offset, angle_a, angle_b,
                 output ready);
endinterface

interface tft_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        feed_rate;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic signed [31:0] rate_a;
   logic signed [31:0] rate_b;
   modport source (output valid, feed_rate, vel_x, vel_y, vel_z, rate_a, rate_b,
                   input ready);
   modport sink (input valid, feed_rate, vel_x, vel_y, vel_z, rate_a, rate_b,
                 output ready);
endinterface

interface tft_csr_if;
   logic        valid;
   logic        ready;
   logic [16:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tool_tip_feedrate_five_axis.sv =====
// ----------------------------------------------------------------------------
// tool_tip_feedrate_five_axis
// Five axis tool tip feedrate and axis velocities from servo position samples.
// ----------------------------------------------------------------------------
//  port      modport  carries
//  req_chan  sink     pos_x, pos_y, pos_z, tool_offset, angle_a, angle_b
//  rsp_chan  source   feed_rate, vel_x, vel_y, vel_z, rate_a, rate_b
//  csr_chan  sink     sample_rate (17 bits), always ready
//
// In the back end, every velocity, cross term, series term and square of a
// sample goes through the single shared multiplier.
// The sample differencing is done on arrival, so two samples can wait in
// the queue while the back end works and a result waits on rsp_chan.
// Synchronous reset clears the previous sample to zero and the rate to 1000.
// ----------------------------------------------------------------------------
`default_nettype none

module tool_tip_feedrate_five_axis (
   input  wire logic clock,
   input  wire logic reset,
   tft_req_if.sink   req_chan,
   tft_rsp_if.source rsp_chan,
   tft_csr_if.sink   csr_chan
);

   logic [16:0]       sample_rate_ff;
   logic              push_valid, push_ready;
   tft_pkg::item_type push_item;
   logic              q_valid, q_pop;
   tft_pkg::item_type q_item;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= tft_pkg::RateReset;
      end else if (csr_chan.valid) begin
         sample_rate_ff <= csr_chan.data;
      end
   end

   tft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   tft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_item  (q_item)
   );

   tft_back u_back (
      .clock       (clock),
      .reset       (reset),
      .sample_rate (sample_rate_ff),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_data      (q_item),
      .rsp         (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== rtl/core/tft_front.sv =====
// ----------------------------------------------------------------------------
// tft_front
// Takes samples, applies the tool offset and differences against the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module tft_front (
   input  wire logic         clock,
   input  wire logic         reset,
   tft_req_if.sink           req,
   input  wire logic         push_ready,
   output logic              push_valid,
   output tft_pkg::item_type push_item
);

   logic signed [31:0] prev_x_ff, prev_y_ff, prev_z_ff, prev_a_ff, prev_b_ff;
   logic signed [32:0] z_diff;
   logic signed [31:0] z_off;

   assign z_diff = {req.pos_z[31], req.pos_z} - {req.tool_offset[31], req.tool_offset};
   assign z_off  = tft_pkg::sat34({z_diff[32], z_diff});

   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   always_comb begin
      push_item.x  = req.pos_x;
      push_item.y  = req.pos_y;
      push_item.z  = z_off;
      push_item.a  = req.angle_a;
      push_item.dx = {req.pos_x[31], req.pos_x} - {prev_x_ff[31], prev_x_ff};
      push_item.dy = {req.pos_y[31], req.pos_y} - {prev_y_ff[31], prev_y_ff};
      push_item.dz = {z_off[31], z_off} - {prev_z_ff[31], prev_z_ff};
      push_item.da = {req.angle_a[31], req.angle_a} - {prev_a_ff[31], prev_a_ff};
      push_item.db = {req.angle_b[31], req.angle_b} - {prev_b_ff[31], prev_b_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         prev_z_ff <= '0;
         prev_a_ff <= '0;
         prev_b_ff <= '0;
      end else if (req.valid && push_ready) begin
         prev_x_ff <= req.pos_x;
         prev_y_ff <= req.pos_y;
         prev_z_ff <= z_off;
         prev_a_ff <= req.angle_a;
         prev_b_ff <= req.angle_b;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tft_queue.sv =====
// ----------------------------------------------------------------------------
// tft_queue
// Two-entry queue of differenced samples between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tft_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire tft_pkg::item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_pop,
   output tft_pkg::item_type      out_item
);

   tft_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> count_ff == $past(count_ff) + 2'($past(push)) - 2'($past(pop)))
      else $error("queue count does not follow push and pop");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 2'd1) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/core/tft_mul.sv =====
// ----------------------------------------------------------------------------
// tft_mul
// Shared 33x33 magnitude multiplier with a registered product and rounding shift.
// ----------------------------------------------------------------------------
`default_nettype none

module tft_mul (
   input  wire logic                clock,
   input  wire tft_pkg::mul_req_type req,
   output logic [65:0]              prod
);

   logic [65:0] product_ff;
   logic [5:0]  sh_ff;
   logic        rnd_ff;
   logic [66:0] rnd_add;
   logic [66:0] rounded;

   always_ff @(posedge clock) begin
      product_ff <= 66'(req.a) * 66'(req.b);
      sh_ff      <= req.sh;
      rnd_ff     <= req.rnd;
   end

   assign rnd_add = rnd_ff ? ((67'(1) << sh_ff) >> 1) : 67'(0);
   assign rounded = 67'(product_ff) + rnd_add;
   assign prod    = 66'(rounded >> sh_ff);

endmodule

`default_nettype wire

// ===== rtl/core/tft_back.sv =====
// ----------------------------------------------------------------------------
// tft_back
// Sequencer that computes velocities, the rotary cross term and the feedrate.
// ----------------------------------------------------------------------------
`default_nettype none

module tft_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [16:0]       sample_rate,
   input  wire logic              q_valid,
   output logic                   q_pop,
   input  wire tft_pkg::item_type q_data,
   tft_rsp_if.source              rsp
);

   typedef enum logic [3:0] {
      S_IDLE, S_ISSUE, S_CAP, S_MOD, S_QSET, S_CORR, S_QUAD, S_SQRT, S_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_XV, OP_YV, OP_ZV, OP_AV, OP_BV, OP_WA, OP_WB, OP_XR, OP_X2,
      OP_NS, OP_QS, OP_NC, OP_QC, OP_WY, OP_WZ,
      OP_T1, OP_T2, OP_T3, OP_T4, OP_T5, OP_T6, OP_SX, OP_SY, OP_SZ
   } op_type;

   state_type          state_ff;
   op_type             op_ff;
   logic [3:0]         k_ff;
   logic [4:0]         cnt_ff;
   tft_pkg::item_type  item_ff;
   logic signed [31:0] xv_ff, yv_ff, zv_ff, av_ff, bv_ff, wa_ff, wb_ff;
   logic signed [31:0] sa_ff, ca_ff, wy_ff, wz_ff;
   logic [32:0]        ang_ff;
   logic               neg_a_ff;
   logic [1:0]         q_ff;
   logic [22:0]        rr_ff;
   logic [31:0]        xr_ff, x2_ff, ts_ff, tc_ff, n_ff, q0_ff;
   logic signed [33:0] s_ff, c_ff, vx_ff, vy_ff, vz_ff;
   logic [63:0]        sum_ff;
   logic [34:0]        rem_ff;
   logic [31:0]        root_ff;
   logic               rsp_valid_ff;
   logic [31:0]        feed_ff;
   logic signed [31:0] out_vx_ff, out_vy_ff, out_vz_ff, out_ra_ff, out_rb_ff;

   tft_pkg::mul_req_type mreq;
   logic               mneg;
   logic [65:0]        prod;
   logic signed [31:0] t;
   logic signed [33:0] t34;
   logic signed [31:0] vsq;

   logic [8:0]         den;
   logic [40:0]        qd_prod;
   logic [40:0]        qd_rem;
   logic [31:0]        qcorr;

   logic [32:0]        m_ang;
   logic [1:0]         quad;
   logic [32:0]        rr_full;
   logic signed [33:0] s_cl, c_cl;
   logic [35:0]        trial, cand;

   tft_mul u_mul (
      .clock (clock),
      .req   (mreq),
      .prod  (prod)
   );

   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign t     = tft_pkg::sat_mag(prod, mneg);
   assign t34   = {{2{t[31]}}, t};

   always_comb begin
      mreq = '0;
      mneg = 1'b0;
      vsq  = '0;
      case (op_ff)
         OP_XV: begin
            mreq.a = tft_pkg::mag33(item_ff.dx);
            mreq.b = 33'(sample_rate);
            mneg   = item_ff.dx[32];
         end
         OP_YV: begin
            mreq.a = tft_pkg::mag33(item_ff.dy);
            mreq.b = 33'(sample_rate);
            mneg   = item_ff.dy[32];
         end
         OP_ZV: begin
            mreq.a = tft_pkg::mag33(item_ff.dz);
            mreq.b = 33'(sample_rate);
            mneg   = item_ff.dz[32];
         end
         OP_AV: begin
            mreq.a = tft_pkg::mag33(item_ff.da);
            mreq.b = 33'(sample_rate);
            mneg   = item_ff.da[32];
         end
         OP_BV: begin
            mreq.a = tft_pkg::mag33(item_ff.db);
            mreq.b = 33'(sample_rate);
            mneg   = item_ff.db[32];
         end
         OP_WA: begin
            mreq.a   = tft_pkg::mag33({av_ff[31], av_ff});
            mreq.b   = tft_pkg::Deg2Rad;
            mreq.sh  = 6'd32;
            mreq.rnd = 1'b1;
            mneg     = av_ff[31];
         end
         OP_WB: begin
            mreq.a   = tft_pkg::mag33({bv_ff[31], bv_ff});
            mreq.b   = tft_pkg::Deg2Rad;
            mreq.sh  = 6'd32;
            mreq.rnd = 1'b1;
            mneg     = bv_ff[31];
         end
         OP_XR: begin
            mreq.a   = 33'(rr_ff);
            mreq.b   = tft_pkg::Deg2Rad;
            mreq.sh  = 6'd18;
            mreq.rnd = 1'b1;
         end
         OP_X2: begin
            mreq.a  = 33'(xr_ff);
            mreq.b  = 33'(xr_ff);
            mreq.sh = 6'd30;
         end
         OP_NS: begin
            mreq.a  = 33'(ts_ff);
            mreq.b  = 33'(x2_ff);
            mreq.sh = 6'd30;
         end
         OP_QS: begin
            mreq.a  = 33'(n_ff);
            mreq.b  = 33'(tft_pkg::recip_sin(k_ff));
            mreq.sh = 6'd32;
         end
         OP_NC: begin
            mreq.a  = 33'(tc_ff);
            mreq.b  = 33'(x2_ff);
            mreq.sh = 6'd30;
         end
         OP_QC: begin
            mreq.a  = 33'(n_ff);
            mreq.b  = 33'(tft_pkg::recip_cos(k_ff));
            mreq.sh = 6'd32;
         end
         OP_WY: begin
            mreq.a   = tft_pkg::mag33({sa_ff[31], sa_ff});
            mreq.b   = tft_pkg::mag33({wb_ff[31], wb_ff});
            mreq.sh  = 6'd30;
            mreq.rnd = 1'b1;
            mneg     = sa_ff[31] ^ wb_ff[31];
         end
         OP_WZ: begin
            mreq.a   = tft_pkg::mag33({ca_ff[31], ca_ff});
            mreq.b   = tft_pkg::mag33({wb_ff[31], wb_ff});
            mreq.sh  = 6'd30;
            mreq.rnd = 1'b1;
            mneg     = ca_ff[31] ^ wb_ff[31];
         end
         OP_T1: begin
            mreq.a   = tft_pkg::mag33({item_ff.y[31], item_ff.y});
            mreq.b   = tft_pkg::mag33({wz_ff[31], wz_ff});
            mreq.sh  = 6'd16;
            mreq.rnd = 1'b1;
            mneg     = item_ff.y[31] ^ wz_ff[31];
         end
         OP_T2: begin
            mreq.a   = tft_pkg::mag33({item_ff.z[31], item_ff.z});
            mreq.b   = tft_pkg::mag33({wy_ff[31], wy_ff});
            mreq.sh  = 6'd16;
            mreq.rnd = 1'b1;
            mneg     = item_ff.z[31] ^ wy_ff[31];
         end
         OP_T3: begin
            mreq.a   = tft_pkg::mag33({item_ff.z[31], item_ff.z});
            mreq.b   = tft_pkg::mag33({wa_ff[31], wa_ff});
            mreq.sh  = 6'd16;
            mreq.rnd = 1'b1;
            mneg     = item_ff.z[31] ^ wa_ff[31];
         end
         OP_T4: begin
            mreq.a   = tft_pkg::mag33({item_ff.x[31], item_ff.x});
            mreq.b   = tft_pkg::mag33({wz_ff[31], wz_ff});
            mreq.sh  = 6'd16;
            mreq.rnd = 1'b1;
            mneg     = item_ff.x[31] ^ wz_ff[31];
         end
         OP_T5: begin
            mreq.a   = tft_pkg::mag33({item_ff.x[31], item_ff.x});
            mreq.b   = tft_pkg::mag33({wy_ff[31], wy_ff});
            mreq.sh  = 6'd16;
            mreq.rnd = 1'b1;
            mneg     = item_ff.x[31] ^ wy_ff[31];
         end
         OP_T6: begin
            mreq.a   = tft_pkg::mag33({item_ff.y[31], item_ff.y});
            mreq.b   = tft_pkg::mag33({wa_ff[31], wa_ff});
            mreq.sh  = 6'd16;
            mreq.rnd = 1'b1;
            mneg     = item_ff.y[31] ^ wa_ff[31];
         end
         OP_SX: begin
            vsq    = tft_pkg::sat34(vx_ff);
            mreq.a = tft_pkg::mag33({vsq[31], vsq});
            mreq.b = tft_pkg::mag33({vsq[31], vsq});
         end
         OP_SY: begin
            vsq    = tft_pkg::sat34(vy_ff);
            mreq.a = tft_pkg::mag33({vsq[31], vsq});
            mreq.b = tft_pkg::mag33({vsq[31], vsq});
         end
         OP_SZ: begin
            vsq    = tft_pkg::sat34(vz_ff);
            mreq.a = tft_pkg::mag33({vsq[31], vsq});
            mreq.b = tft_pkg::mag33({vsq[31], vsq});
         end
         default: begin
            mreq = '0;
         end
      endcase
   end

   // The reciprocal estimate is at most one below the true quotient.
   always_comb begin
      den     = (op_ff == OP_QS) ? tft_pkg::den_sin(k_ff) : tft_pkg::den_cos(k_ff);
      qd_prod = 41'(q0_ff) * 41'(den);
      qd_rem  = 41'(n_ff) - qd_prod;
      qcorr   = q0_ff + 32'(qd_rem >= 41'(den));
   end

   always_comb begin
      m_ang = (neg_a_ff && (ang_ff != 33'd0)) ? (tft_pkg::Turn - ang_ff) : ang_ff;
      if (m_ang >= 33'(3) * tft_pkg::Quarter) begin
         quad = 2'd3;
      end else if (m_ang >= 33'(2) * tft_pkg::Quarter) begin
         quad = 2'd2;
      end else if (m_ang >= tft_pkg::Quarter) begin
         quad = 2'd1;
      end else begin
         quad = 2'd0;
      end
      rr_full = m_ang - 33'(quad) * tft_pkg::Quarter;
   end

   always_comb begin
      if (s_ff > $signed({2'b00, tft_pkg::One30})) begin
         s_cl = $signed({2'b00, tft_pkg::One30});
      end else if (s_ff < -$signed({2'b00, tft_pkg::One30})) begin
         s_cl = -$signed({2'b00, tft_pkg::One30});
      end else begin
         s_cl = s_ff;
      end
      if (c_ff > $signed({2'b00, tft_pkg::One30})) begin
         c_cl = $signed({2'b00, tft_pkg::One30});
      end else if (c_ff < -$signed({2'b00, tft_pkg::One30})) begin
         c_cl = -$signed({2'b00, tft_pkg::One30});
      end else begin
         c_cl = c_ff;
      end
   end

   assign trial = {rem_ff[33:0], sum_ff[63:62]};
   assign cand  = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_XV;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff  <= q_data;
                  ang_ff   <= tft_pkg::mag33({q_data.a[31], q_data.a});
                  neg_a_ff <= q_data.a[31];
                  op_ff    <= OP_XV;
                  state_ff <= S_ISSUE;
               end
            end
            S_ISSUE: begin
               state_ff <= S_CAP;
            end
            S_CAP: begin
               if (op_ff == OP_WB) begin
                  state_ff <= S_MOD;
               end else if (op_ff inside {OP_QS, OP_QC}) begin
                  state_ff <= S_CORR;
               end else if (op_ff == OP_SZ) begin
                  state_ff <= S_SQRT;
               end else begin
                  state_ff <= S_ISSUE;
               end
               case (op_ff)
                  OP_XV: begin xv_ff <= t; op_ff <= OP_YV; end
                  OP_YV: begin yv_ff <= t; op_ff <= OP_ZV; end
                  OP_ZV: begin zv_ff <= t; op_ff <= OP_AV; end
                  OP_AV: begin av_ff <= t; op_ff <= OP_BV; end
                  OP_BV: begin bv_ff <= t; op_ff <= OP_WA; end
                  OP_WA: begin wa_ff <= t; op_ff <= OP_WB; end
                  OP_WB: begin
                     wb_ff  <= t;
                     cnt_ff <= 5'd6;
                  end
                  OP_XR: begin xr_ff <= prod[31:0]; op_ff <= OP_X2; end
                  OP_X2: begin
                     x2_ff <= prod[31:0];
                     ts_ff <= xr_ff;
                     tc_ff <= tft_pkg::One30;
                     s_ff  <= $signed({2'b00, xr_ff});
                     c_ff  <= $signed({2'b00, tft_pkg::One30});
                     k_ff  <= 4'd1;
                     op_ff <= OP_NS;
                  end
                  OP_NS: begin n_ff <= prod[31:0]; op_ff <= OP_QS; end
                  OP_QS: begin q0_ff <= prod[31:0]; end
                  OP_NC: begin n_ff <= prod[31:0]; op_ff <= OP_QC; end
                  OP_QC: begin q0_ff <= prod[31:0]; end
                  OP_WY: begin wy_ff <= t; op_ff <= OP_WZ; end
                  OP_WZ: begin wz_ff <= t; op_ff <= OP_T1; end
                  OP_T1: begin vx_ff <= {{2{xv_ff[31]}}, xv_ff} + t34; op_ff <= OP_T2; end
                  OP_T2: begin vx_ff <= vx_ff - t34; op_ff <= OP_T3; end
                  OP_T3: begin vy_ff <= {{2{yv_ff[31]}}, yv_ff} + t34; op_ff <= OP_T4; end
                  OP_T4: begin vy_ff <= vy_ff - t34; op_ff <= OP_T5; end
                  OP_T5: begin vz_ff <= {{2{zv_ff[31]}}, zv_ff} + t34; op_ff <= OP_T6; end
                  OP_T6: begin vz_ff <= vz_ff - t34; op_ff <= OP_SX; end
                  OP_SX: begin sum_ff <= prod[63:0]; op_ff <= OP_SY; end
                  OP_SY: begin sum_ff <= sum_ff + prod[63:0]; op_ff <= OP_SZ; end
                  OP_SZ: begin
                     sum_ff  <= sum_ff + prod[63:0];
                     rem_ff  <= '0;
                     root_ff <= '0;
                     cnt_ff  <= 5'd31;
                  end
                  default: begin
                     op_ff <= OP_XV;
                  end
               endcase
            end
            S_MOD: begin
               if (ang_ff >= (tft_pkg::Turn << cnt_ff)) begin
                  ang_ff <= ang_ff - (tft_pkg::Turn << cnt_ff);
               end
               if (cnt_ff == 5'd0) begin
                  state_ff <= S_QSET;
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
            S_QSET: begin
               q_ff     <= quad;
               rr_ff    <= rr_full[22:0];
               op_ff    <= OP_XR;
               state_ff <= S_ISSUE;
            end
            S_CORR: begin
               if (op_ff == OP_QS) begin
                  ts_ff    <= qcorr;
                  s_ff     <= k_ff[0] ? s_ff - $signed({2'b00, qcorr})
                                      : s_ff + $signed({2'b00, qcorr});
                  op_ff    <= OP_NC;
                  state_ff <= S_ISSUE;
               end else begin
                  tc_ff <= qcorr;
                  c_ff  <= k_ff[0] ? c_ff - $signed({2'b00, qcorr})
                                   : c_ff + $signed({2'b00, qcorr});
                  if (k_ff == 4'd9) begin
                     state_ff <= S_QUAD;
                  end else begin
                     k_ff     <= k_ff + 4'd1;
                     op_ff    <= OP_NS;
                     state_ff <= S_ISSUE;
                  end
               end
            end
            S_QUAD: begin
               case (q_ff)
                  2'd0: begin sa_ff <= s_cl[31:0]; ca_ff <= c_cl[31:0]; end
                  2'd1: begin sa_ff <= c_cl[31:0]; ca_ff <= 32'(-s_cl); end
                  2'd2: begin sa_ff <= 32'(-s_cl); ca_ff <= 32'(-c_cl); end
                  default: begin sa_ff <= 32'(-c_cl); ca_ff <= s_cl[31:0]; end
               endcase
               op_ff    <= OP_WY;
               state_ff <= S_ISSUE;
            end
            S_SQRT: begin
               if (trial >= cand) begin
                  rem_ff  <= 35'(trial - cand);
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff  <= 35'(trial);
                  root_ff <= {root_ff[30:0], 1'b0};
               end
               sum_ff <= {sum_ff[61:0], 2'b00};
               if (cnt_ff == 5'd0) begin
                  state_ff <= S_OUT;
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  feed_ff      <= root_ff;
                  out_vx_ff    <= xv_ff;
                  out_vy_ff    <= yv_ff;
                  out_vz_ff    <= zv_ff;
                  out_ra_ff    <= av_ff;
                  out_rb_ff    <= bv_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.feed_rate = feed_ff;
   assign rsp.vel_x     = out_vx_ff;
   assign rsp.vel_y     = out_vy_ff;
   assign rsp.vel_z     = out_vz_ff;
   assign rsp.rate_a    = out_ra_ff;
   assign rsp.rate_b    = out_rb_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tool_tip_feedrate_five_axis_tb.sv =====
// ----------------------------------------------------------------------------
// tool_tip_feedrate_five_axis_tb
// Drives servo samples into the tool tip feedrate core under several sample
// rates and compares every result word against a bit exact prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tool_tip_feedrate_five_axis_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] tool_offset;
      logic signed [31:0] angle_a;
      logic signed [31:0] angle_b;
   } sample_type;

   typedef struct {
      logic [31:0]        feed_rate;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] rate_a;
      logic signed [31:0] rate_b;
   } motion_type;

   class feedrate_scoreboard;
      longint     rate;
      longint     last_x, last_y, last_z, last_a, last_b;
      motion_type pending[$];
      int         errors;

      function new();
         rate = 1000;
         last_x = 0; last_y = 0; last_z = 0; last_a = 0; last_b = 0;
         errors = 0;
      endfunction

      static function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // Product scaled down by 2^sh, rounded half away from zero, saturated.
      static function longint mul_round(longint a, longint b, int sh);
         bit          neg;
         bit [127:0]  ma, mb, p;
         bit [127:0]  lim;
         neg = (a < 0) != (b < 0);
         ma = (a < 0) ? 128'(64'(-a)) : 128'(64'(a));
         mb = (b < 0) ? 128'(64'(-b)) : 128'(64'(b));
         p = ma * mb;
         if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
         lim = 128'd2147483647 + 128'(neg);
         if (p > lim) p = lim;
         return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
      endfunction

      static function void sin_cos(longint ang, output longint s_out, output longint c_out);
         longint            turn, quarter, m, q, r, s, c;
         longint unsigned   x, x2, ts, tc;
         turn = 360 << 16;
         quarter = 90 << 16;
         m = ang % turn;
         if (m < 0) m += turn;
         q = m / quarter;
         r = m - q * quarter;
         x = (longint'(r) * 74961321 + (64'd1 << 17)) >> 18;
         x2 = (x * x) >> 30;
         ts = x;
         tc = 64'd1 << 30;
         s = ts;
         c = tc;
         for (int k = 1; k <= 9; k++) begin
            ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
            tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
               s -= ts; c -= tc;
            end else begin
               s += ts; c += tc;
            end
         end
         if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
         if (s < -(64'sd1 << 30)) s = -(64'sd1 << 30);
         if (c > (64'sd1 << 30)) c = 64'sd1 << 30;
         if (c < -(64'sd1 << 30)) c = -(64'sd1 << 30);
         case (q)
            0: begin s_out = s; c_out = c; end
            1: begin s_out = c; c_out = -s; end
            2: begin s_out = -s; c_out = -c; end
            default: begin s_out = -c; c_out = s; end
         endcase
      endfunction

      function void note_sample(sample_type smp);
         longint     x, y, z, a, b, xv, yv, zv, av, bv, wa, wb, sa, ca, wy, wz, vx, vy, vz;
         bit [127:0] sum, cand;
         bit [63:0]  root, mag;
         motion_type res;
         x = smp.pos_x; y = smp.pos_y; a = smp.angle_a; b = smp.angle_b;
         z = clamp32(longint'(smp.pos_z) - longint'(smp.tool_offset));
         xv = mul_round(x - last_x, rate, 0);
         yv = mul_round(y - last_y, rate, 0);
         zv = mul_round(z - last_z, rate, 0);
         av = mul_round(a - last_a, rate, 0);
         bv = mul_round(b - last_b, rate, 0);
         wa = mul_round(av, 74961321, 32);
         wb = mul_round(bv, 74961321, 32);
         sin_cos(a, sa, ca);
         wy = mul_round(sa, wb, 30);
         wz = mul_round(ca, wb, 30);
         vx = clamp32(xv + mul_round(y, wz, 16) - mul_round(z, wy, 16));
         vy = clamp32(yv + mul_round(z, wa, 16) - mul_round(x, wz, 16));
         vz = clamp32(zv + mul_round(x, wy, 16) - mul_round(y, wa, 16));
         sum = 0;
         mag = (vx < 0) ? 64'(-vx) : 64'(vx); sum += 128'(mag) * 128'(mag);
         mag = (vy < 0) ? 64'(-vy) : 64'(vy); sum += 128'(mag) * 128'(mag);
         mag = (vz < 0) ? 64'(-vz) : 64'(vz); sum += 128'(mag) * 128'(mag);
         root = 0;
         for (int i = 49; i >= 0; i--) begin
            cand = 128'(root | (64'd1 << i));
            if (cand * cand <= sum) root = cand[63:0];
         end
         if (root > 64'hffff_ffff) root = 64'hffff_ffff;
         res.feed_rate = root[31:0];
         res.vel_x = xv[31:0];
         res.vel_y = yv[31:0];
         res.vel_z = zv[31:0];
         res.rate_a = av[31:0];
         res.rate_b = bv[31:0];
         pending.push_back(res);
         last_x = x; last_y = y; last_z = z; last_a = a; last_b = b;
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
         errors++;
      endtask

      task check_result(motion_type got);
         motion_type want;
         if (pending.size() == 0) begin
            report("unexpected word", got.feed_rate, 0);
            return;
         end
         want = pending.pop_front();
         if (got.feed_rate !== want.feed_rate) report("feed_rate", got.feed_rate, want.feed_rate);
         if (got.vel_x !== want.vel_x) report("vel_x", got.vel_x, want.vel_x);
         if (got.vel_y !== want.vel_y) report("vel_y", got.vel_y, want.vel_y);
         if (got.vel_z !== want.vel_z) report("vel_z", got.vel_z, want.vel_z);
         if (got.rate_a !== want.rate_a) report("rate_a", got.rate_a, want.rate_a);
         if (got.rate_b !== want.rate_b) report("rate_b", got.rate_b, want.rate_b);
      endtask
   endclass

   logic clock;
   logic reset;
   bit   calm;

   tft_req_if req_chan ();
   tft_rsp_if rsp_chan ();
   tft_csr_if csr_chan ();

   feedrate_scoreboard board = new();

   tool_tip_feedrate_five_axis dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      motion_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.feed_rate = rsp_chan.feed_rate;
         got.vel_x = rsp_chan.vel_x;
         got.vel_y = rsp_chan.vel_y;
         got.vel_z = rsp_chan.vel_z;
         got.rate_a = rsp_chan.rate_a;
         got.rate_b = rsp_chan.rate_b;
         board.check_result(got);
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   task automatic send_sample(sample_type smp);
      req_chan.valid <= 1'b1;
      req_chan.pos_x <= smp.pos_x;
      req_chan.pos_y <= smp.pos_y;
      req_chan.pos_z <= smp.pos_z;
      req_chan.tool_offset <= smp.tool_offset;
      req_chan.angle_a <= smp.angle_a;
      req_chan.angle_b <= smp.angle_b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_sample(smp);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic write_rate(logic [16:0] value);
      req_chan.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      board.rate = value;
      csr_chan.valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] near(logic signed [31:0] base, int span);
      return base + $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic sample_type wild_sample();
      sample_type s;
      s.pos_x = $urandom; s.pos_y = $urandom; s.pos_z = $urandom;
      s.tool_offset = $urandom; s.angle_a = $urandom; s.angle_b = $urandom;
      return s;
   endfunction

   task automatic run_phase(int count);
      sample_type s;
      int         span;
      s = wild_sample();
      s.pos_x >>>= 8; s.pos_y >>>= 8; s.pos_z >>>= 8; s.tool_offset >>>= 12;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 2) begin
            s = wild_sample();
            send_sample(s);
            s.pos_x >>>= 8; s.pos_y >>>= 8; s.pos_z >>>= 8;
         end else begin
            span = 1 << $urandom_range(0, 18);
            s.pos_x = near(s.pos_x, span);
            s.pos_y = near(s.pos_y, span);
            s.pos_z = near(s.pos_z, span);
            s.angle_a = near(s.angle_a, span);
            s.angle_b = near(s.angle_b, span);
            send_sample(s);
         end
      end
   endtask

   initial begin
      sample_type   s;
      logic [31:0]  edges[6];
      logic [16:0]  rates[5];
      reset <= 1'b1;
      calm = 1'b0;
      req_chan.valid <= 1'b0;
      req_chan.pos_x <= '0;
      req_chan.pos_y <= '0;
      req_chan.pos_z <= '0;
      req_chan.tool_offset <= '0;
      req_chan.angle_a <= '0;
      req_chan.angle_b <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset rate: extremes, quadrant edges, offset clamp.
      edges = '{32'sh0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 32'sh7fff_ffff, 32'sh8000_0000};
      foreach (edges[i]) begin
         s.pos_x = edges[i]; s.pos_y = edges[(i + 1) % 6]; s.pos_z = edges[(i + 2) % 6];
         s.tool_offset = edges[(i + 3) % 6];
         s.angle_a = edges[(i + 4) % 6]; s.angle_b = edges[(i + 5) % 6];
         send_sample(s);
      end
      for (int q = -1; q <= 5; q++) begin
         s.pos_x = 32'sd10 << 16; s.pos_y = -32'sd20 << 16; s.pos_z = 32'sd5 << 16;
         s.tool_offset = 32'sd2 << 16;
         s.angle_a = (q * 90) << 16; s.angle_b = (q * 45 + 1) << 16;
         send_sample(s);
      end
      s.pos_z = 32'sh7fff_0000; s.tool_offset = 32'sh8000_0000;
      send_sample(s);
      s.pos_z = 32'sh8000_0000; s.tool_offset = 32'sh7fff_ffff;
      send_sample(s);
      run_phase(100);

      rates = '{17'd1, 17'h1ffff, 17'd0, 17'd100000, 17'd1000};
      foreach (rates[i]) begin
         write_rate(rates[i]);
         run_phase(100);
      end
      write_rate(17'($urandom_range(1, 100000)));
      run_phase(150);
      calm = 1'b1;
      run_phase(120);
      req_chan.valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/tft_pkg.sv
rtl/core/tft_channels.sv
rtl/core/tft_front.sv
rtl/core/tft_queue.sv
rtl/core/tft_mul.sv
rtl/core/tft_back.sv
rtl/core/tool_tip_feedrate_five_axis.sv
tb/sv/tool_tip_feedrate_five_axis_tb.sv
